[hw/rtl/pte_pkg.sv]
package pte_pkg;

  // Event kinds carried on the result channel
  localparam logic [1:0] KIND_DOWN = 2'd0;
  localparam logic [1:0] KIND_MOVE = 2'd1;
  localparam logic [1:0] KIND_UP   = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_SWAP_AXES     = 3'd2;
  localparam logic [2:0] CFG_INVERT_X      = 3'd3;
  localparam logic [2:0] CFG_INVERT_Y      = 3'd4;

  localparam logic [15:0] RESET_WIDTH  = 16'd800;
  localparam logic [15:0] RESET_HEIGHT = 16'd480;

  typedef struct packed {
    logic [15:0] screen_width;
    logic [15:0] screen_height;
    logic        swap_axes;
    logic        invert_x;
    logic        invert_y;
  } pte_cfg_t;

  typedef struct packed {
    logic [3:0]  touch_count;
    logic [2:0]  slot_index;
    logic [7:0]  point_id;
    logic [15:0] raw_x;
    logic [15:0] raw_y;
  } pte_point_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] event_x;
    logic [15:0] event_y;
    logic [1:0]  event_kind;
  } pte_result_t;

endpackage

[hw/rtl/pte_if.sv]
interface pte_touch_if;
  logic        valid;
  logic        ready;
  logic [3:0]  touch_count;
  logic [2:0]  slot_index;
  logic [7:0]  point_id;
  logic [15:0] raw_x;
  logic [15:0] raw_y;

  modport source (output valid, output touch_count, output slot_index, output point_id,
                  output raw_x, output raw_y, input ready);
  modport sink   (input valid, input touch_count, input slot_index, input point_id,
                  input raw_x, input raw_y, output ready);
endinterface

interface pte_event_if;
  logic        valid;
  logic        ready;
  logic [15:0] event_x;
  logic [15:0] event_y;
  logic [1:0]  event_kind;

  modport source (output valid, output event_x, output event_y, output event_kind,
                  input ready);
  modport sink   (input valid, input event_x, input event_y, input event_kind,
                  output ready);
endinterface

[hw/rtl/pte_map.sv]
module pte_map
  import pte_pkg::*;
(
  input  pte_cfg_t    cfg,
  input  logic [15:0] raw_x,
  input  logic [15:0] raw_y,
  output logic [15:0] map_x,
  output logic [15:0] map_y
);

  logic [15:0] sw_x;
  logic [15:0] sw_y;
  logic [15:0] top_x;
  logic [15:0] top_y;
  logic [15:0] lim_x;
  logic [15:0] lim_y;

  assign sw_x  = cfg.swap_axes ? raw_y : raw_x;
  assign sw_y  = cfg.swap_axes ? raw_x : raw_y;

  // A dimension of zero wraps to the full 16-bit range here.
  assign top_x = cfg.screen_width - 16'd1;
  assign top_y = cfg.screen_height - 16'd1;

  assign lim_x = (sw_x < cfg.screen_width) ? sw_x : top_x;
  assign lim_y = (sw_y < cfg.screen_height) ? sw_y : top_y;

  assign map_x = cfg.invert_x ? (top_x - lim_x) : lim_x;
  assign map_y = cfg.invert_y ? (top_y - lim_y) : lim_y;

endmodule

[hw/rtl/pte_track.sv]
module pte_track
  import pte_pkg::*;
#(
  parameter int MAX_POINTS = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  pte_point_t  item,
  input  logic [15:0] map_x,
  input  logic [15:0] map_y,
  output pte_result_t res,
  output logic        contact_down
);

  localparam logic [3:0] MaxCount = 4'(MAX_POINTS);

  logic        report_settled;
  logic [7:0]  tracked_id;
  logic [15:0] last_pos_x;
  logic [15:0] last_pos_y;

  logic        contact_down_next;
  logic        report_settled_next;
  logic [7:0]  tracked_id_next;
  logic [15:0] last_pos_x_next;
  logic [15:0] last_pos_y_next;
  logic        settled_eff;
  logic [3:0]  slot_ext;

  assign slot_ext = {1'b0, item.slot_index};

  always_comb begin
    contact_down_next   = contact_down;
    report_settled_next = report_settled;
    tracked_id_next     = tracked_id;
    last_pos_x_next     = last_pos_x;
    last_pos_y_next     = last_pos_y;
    settled_eff         = (item.slot_index == 3'd0) ? 1'b0 : report_settled;
    res                 = '{hit: 1'b0, event_x: last_pos_x, event_y: last_pos_y,
                            event_kind: KIND_UP};
    if (item.touch_count > MaxCount) begin
      // oversized report: dropped untouched
    end else if (item.touch_count == 4'd0) begin
      report_settled_next = 1'b1;
      if (contact_down) begin
        contact_down_next = 1'b0;
        res.hit           = 1'b1;
      end
    end else begin
      report_settled_next = settled_eff;
      if (slot_ext < item.touch_count && !settled_eff) begin
        if (!contact_down) begin
          if (item.slot_index == 3'd0) begin
            tracked_id_next     = item.point_id;
            last_pos_x_next     = map_x;
            last_pos_y_next     = map_y;
            contact_down_next   = 1'b1;
            report_settled_next = 1'b1;
            res = '{hit: 1'b1, event_x: map_x, event_y: map_y, event_kind: KIND_DOWN};
          end
        end else if (item.point_id == tracked_id) begin
          report_settled_next = 1'b1;
          if (map_x != last_pos_x || map_y != last_pos_y) begin
            last_pos_x_next = map_x;
            last_pos_y_next = map_y;
            res = '{hit: 1'b1, event_x: map_x, event_y: map_y, event_kind: KIND_MOVE};
          end
        end else if (slot_ext == item.touch_count - 4'd1) begin
          // last slot went by without the tracked contact: lift-off
          report_settled_next = 1'b1;
          contact_down_next   = 1'b0;
          res.hit             = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      contact_down   <= 1'b0;
      report_settled <= 1'b0;
      tracked_id     <= 8'd0;
      last_pos_x     <= 16'd0;
      last_pos_y     <= 16'd0;
    end else if (en) begin
      contact_down   <= contact_down_next;
      report_settled <= report_settled_next;
      tracked_id     <= tracked_id_next;
      last_pos_x     <= last_pos_x_next;
      last_pos_y     <= last_pos_y_next;
    end
  end

endmodule

[hw/rtl/primary_touch_event_tracker.sv]
// A point request is held in the input register, and its event, if it gives one, is
// then held in the event register, which drives the event channel.
// Throughput: one point request per cycle while events are taken; a waiting event
// holds the request behind it in the input register and stalls the touch channel.
// Reset (rst, synchronous, active high) drops all pending requests, releases the
// tracked contact and restores the screen to 800 by 480, no swap, no mirroring.
module primary_touch_event_tracker
  import pte_pkg::*;
#(
  parameter int MAX_POINTS = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  pte_touch_if.sink          touch_in,
  pte_event_if.source        event_out
);

  // Configuration registers. Writes must only arrive while the block is idle, so
  // no request in flight sees a change half way through; the block does not enforce it.
  pte_cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width  <= RESET_WIDTH;
      cfg.screen_height <= RESET_HEIGHT;
      cfg.swap_axes     <= 1'b0;
      cfg.invert_x      <= 1'b0;
      cfg.invert_y      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data;
        CFG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data;
        CFG_SWAP_AXES:     cfg.swap_axes     <= cfg_data[0];
        CFG_INVERT_X:      cfg.invert_x      <= cfg_data[0];
        CFG_INVERT_Y:      cfg.invert_y      <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Input register. The request held here is processed in the cycle it moves
  // on, which happens whenever the event register is free or being emptied.
  logic       s1_valid;
  pte_point_t s1_item;
  logic       s1_fire;
  logic       out_valid;
  logic       out_load;

  assign s1_fire        = s1_valid && (!out_valid || event_out.ready);
  assign touch_in.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (touch_in.ready) begin
      s1_valid <= touch_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (touch_in.valid && touch_in.ready) begin
      s1_item <= '{touch_count: touch_in.touch_count, slot_index: touch_in.slot_index,
                   point_id: touch_in.point_id, raw_x: touch_in.raw_x,
                   raw_y: touch_in.raw_y};
    end
  end

  // Screen mapping and contact tracking, both within the one cycle. The
  // tracker updates its state as the request leaves the input register, so the
  // next request already sees the outcome of this one.
  logic [15:0] map_x;
  logic [15:0] map_y;
  pte_result_t res;
  logic        contact_down;

  pte_map u_map (
    .cfg   (cfg),
    .raw_x (s1_item.raw_x),
    .raw_y (s1_item.raw_y),
    .map_x (map_x),
    .map_y (map_y)
  );

  pte_track #(
    .MAX_POINTS (MAX_POINTS)
  ) u_track (
    .clk          (clk),
    .rst          (rst),
    .en           (s1_fire),
    .item         (s1_item),
    .map_x        (map_x),
    .map_y        (map_y),
    .res          (res),
    .contact_down (contact_down)
  );

  // Event register. Requests that give no event pass without touching it.
  logic [15:0] out_x;
  logic [15:0] out_y;
  logic [1:0]  out_kind;

  assign out_load = s1_fire && res.hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (event_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x    <= res.event_x;
      out_y    <= res.event_y;
      out_kind <= res.event_kind;
    end
  end

  assign event_out.valid      = out_valid;
  assign event_out.event_x    = out_x;
  assign event_out.event_y    = out_y;
  assign event_out.event_kind = out_kind;

`ifndef SYNTHESIS
  // A waiting event is never overwritten by a new one.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !event_out.ready |-> !out_load)
    else $error("event register overwritten while stalled");

  // A DOWN event leaves a contact tracked.
  a_down_tracks: assert property (@(posedge clk) disable iff (rst)
    out_load && res.event_kind == KIND_DOWN |=> contact_down)
    else $error("DOWN issued without a tracked contact");

  // An UP event releases the tracked contact.
  a_up_releases: assert property (@(posedge clk) disable iff (rst)
    out_load && res.event_kind == KIND_UP |=> !contact_down)
    else $error("UP issued but contact still tracked");

  // MOVE and UP are only issued for a contact that is down.
  a_needs_contact: assert property (@(posedge clk) disable iff (rst)
    out_load && (res.event_kind == KIND_MOVE || res.event_kind == KIND_UP)
      |-> contact_down)
    else $error("MOVE or UP issued with no contact down");
`endif

endmodule
